// ===== sv/hci_h4_packet_deframer_macros.svh =====
// Assertion macros shared by the H4 deframer checker.
`ifndef HCI_H4_PACKET_DEFRAMER_MACROS_SVH
`define HCI_H4_PACKET_DEFRAMER_MACROS_SVH

// Clocked check, suppressed while reset is high.
`define HCIH4_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define HCIH4_ASSERT_ALWAYS(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/hcih4_pkg.sv =====
// Shared types, constants and helpers of the H4 packet deframer.
`default_nettype none
package hcih4_pkg;

   localparam int HdrDepth = 5;
   localparam int LenW     = 17;
   localparam int CntW     = 3;

   localparam logic [LenW-1:0] MaxLenReset = 17'd260;

   localparam logic [7:0] TYPE_CMD = 8'h01;
   localparam logic [7:0] TYPE_ACL = 8'h02;
   localparam logic [7:0] TYPE_SCO = 8'h03;
   localparam logic [7:0] TYPE_EVT = 8'h04;

   typedef enum logic [1:0] {
      KIND_PKT      = 2'd0,
      KIND_BAD_TYPE = 2'd1,
      KIND_OVERSIZE = 2'd2
   } kind_type;

   typedef logic [HdrDepth-1:0][7:0] hdr_type;

   // Event from the parser to the result stage.
   typedef struct packed {
      logic            valid;
      logic            burst;    // emit a whole header
      kind_type        kind;
      logic [7:0]      data;
      logic            last;
      hdr_type         hdr;
      logic [CntW-1:0] hdr_len;
      logic            empty;    // packet has no payload
   } evt_type;

   // Header length including the type byte; zero for an unknown type.
   function automatic logic [CntW-1:0] header_len(input logic [7:0] t);
      logic [CntW-1:0] hl;
      unique case (t)
         TYPE_CMD: hl = 3'd4;
         TYPE_ACL: hl = 3'd5;
         TYPE_SCO: hl = 3'd4;
         TYPE_EVT: hl = 3'd3;
         default:  hl = 3'd0;
      endcase
      return hl;
   endfunction

endpackage
`default_nettype wire

// ===== sv/hcih4_parse.sv =====
// Input register and header/payload parser of the H4 deframer.
`default_nettype none
module hcih4_parse
   import hcih4_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire logic [7:0]      req_in_byte,
   input  wire logic [LenW-1:0] max_len,
   input  wire logic            evt_ready,
   output      evt_type         evt
);

   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;
   hdr_type         store_ff, store_in;
   logic [CntW-1:0] hdr_count_ff, hdr_count_in;
   logic            in_payload_ff, in_payload_in;
   logic [LenW-1:0] bytes_left_ff, bytes_left_in;

   logic            fire;
   logic [7:0]      b;
   logic [CntW-1:0] hl_new, hl_held;
   logic [15:0]     plen;
   logic [LenW-1:0] total;
   logic [LenW-1:0] left_dec;
   hdr_type         hdr_full;

   assign fire      = in_valid_ff && evt_ready;
   assign req_ready = !in_valid_ff || evt_ready;
   assign b         = in_byte_ff;

   always_comb begin
      in_valid_in   = in_valid_ff;
      store_in      = store_ff;
      hdr_count_in  = hdr_count_ff;
      in_payload_in = in_payload_ff;
      bytes_left_in = bytes_left_ff;

      evt         = '0;
      evt.kind    = KIND_PKT;
      hl_new      = header_len(b);
      hl_held     = header_len(store_ff[0]);
      left_dec    = bytes_left_ff - 17'd1;
      hdr_full    = store_ff;
      hdr_full[hdr_count_ff] = b;

      if (store_ff[0] == TYPE_ACL) begin
         plen = {b, store_ff[3]};
      end else begin
         plen = {8'h00, b};
      end
      total = {14'd0, hl_held} + {1'b0, plen};

      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end else if (fire) begin
         in_valid_in = 1'b0;
      end

      if (fire) begin
         if (in_payload_ff) begin
            evt.valid     = 1'b1;
            evt.data      = b;
            evt.last      = (left_dec == '0);
            bytes_left_in = left_dec;
            if (left_dec == '0) begin
               in_payload_in = 1'b0;
            end
         end else if (hdr_count_ff == '0) begin
            if (hl_new == '0) begin
               evt.valid = 1'b1;
               evt.kind  = KIND_BAD_TYPE;
               evt.data  = b;
               evt.last  = 1'b1;
            end else begin
               store_in[0]  = b;
               hdr_count_in = 3'd1;
            end
         end else if (hdr_count_ff < hl_held - 3'd1) begin
            store_in[hdr_count_ff] = b;
            hdr_count_in           = hdr_count_ff + 3'd1;
         end else begin
            // header complete with this byte
            hdr_count_in = '0;
            evt.valid    = 1'b1;
            if (total > max_len) begin
               evt.kind = KIND_OVERSIZE;
               evt.data = store_ff[0];
               evt.last = 1'b1;
            end else begin
               evt.burst   = 1'b1;
               evt.hdr     = hdr_full;
               evt.hdr_len = hl_held;
               evt.empty   = (plen == '0);
               if (plen != '0) begin
                  in_payload_in = 1'b1;
                  bytes_left_in = {1'b0, plen};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff   <= 1'b0;
         hdr_count_ff  <= '0;
         in_payload_ff <= 1'b0;
         bytes_left_ff <= '0;
      end else begin
         in_valid_ff   <= in_valid_in;
         hdr_count_ff  <= hdr_count_in;
         in_payload_ff <= in_payload_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
      end
      store_ff <= store_in;
   end

endmodule
`default_nettype wire

// ===== sv/hcih4_out.sv =====
// Result register and header burst sequencer of the H4 deframer.
`default_nettype none
module hcih4_out
   import hcih4_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire evt_type    evt,
   output      logic       evt_ready,
   output      logic       rsp_valid,
   input  wire logic       rsp_ready,
   output      logic [1:0] rsp_out_kind,
   output      logic [7:0] rsp_out_byte,
   output      logic       rsp_out_first,
   output      logic       rsp_out_last
);

   logic            rsp_valid_ff, rsp_valid_in;
   kind_type        kind_ff, kind_in;
   logic [7:0]      data_ff, data_in;
   logic            first_ff, first_in;
   logic            last_ff, last_in;
   logic            burst_act_ff, burst_act_in;
   hdr_type         burst_ff, burst_in;
   logic [CntW-1:0] burst_idx_ff, burst_idx_in;
   logic [CntW-1:0] burst_len_ff, burst_len_in;
   logic            burst_empty_ff, burst_empty_in;
   logic            take;
   logic            burst_end;

   assign take      = !rsp_valid_ff || rsp_ready;
   assign evt_ready = take && !burst_act_ff;
   assign burst_end = (burst_idx_ff == burst_len_ff - 3'd1);

   always_comb begin
      rsp_valid_in   = rsp_valid_ff;
      kind_in        = kind_ff;
      data_in        = data_ff;
      first_in       = first_ff;
      last_in        = last_ff;
      burst_act_in   = burst_act_ff;
      burst_in       = burst_ff;
      burst_idx_in   = burst_idx_ff;
      burst_len_in   = burst_len_ff;
      burst_empty_in = burst_empty_ff;

      if (take) begin
         if (burst_act_ff) begin
            rsp_valid_in = 1'b1;
            kind_in      = KIND_PKT;
            data_in      = burst_ff[burst_idx_ff];
            first_in     = 1'b0;
            last_in      = burst_end && burst_empty_ff;
            burst_idx_in = burst_idx_ff + 3'd1;
            if (burst_end) begin
               burst_act_in = 1'b0;
            end
         end else if (evt.valid) begin
            rsp_valid_in = 1'b1;
            if (evt.burst) begin
               // type byte now, the rest of the header follows
               kind_in        = KIND_PKT;
               data_in        = evt.hdr[0];
               first_in       = 1'b1;
               last_in        = 1'b0;
               burst_act_in   = 1'b1;
               burst_in       = evt.hdr;
               burst_idx_in   = 3'd1;
               burst_len_in   = evt.hdr_len;
               burst_empty_in = evt.empty;
            end else begin
               kind_in  = evt.kind;
               data_in  = evt.data;
               first_in = 1'b0;
               last_in  = evt.last;
            end
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         burst_act_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         burst_act_ff <= burst_act_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff        <= kind_in;
      data_ff        <= data_in;
      first_ff       <= first_in;
      last_ff        <= last_in;
      burst_ff       <= burst_in;
      burst_idx_ff   <= burst_idx_in;
      burst_len_ff   <= burst_len_in;
      burst_empty_ff <= burst_empty_in;
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_out_kind  = kind_ff;
   assign rsp_out_byte  = data_ff;
   assign rsp_out_first = first_ff;
   assign rsp_out_last  = last_ff;

endmodule
`default_nettype wire

// ===== sv/hci_h4_packet_deframer.sv =====
// H4 deframer: a byte moves from the input register to the result register. One byte
// is taken per cycle unless the output stalls or a header burst holds it off; a header
// that completes within the length limit is sent out byte by byte from the result
// register. Payload bytes and error items pass at one per cycle unless stalled.
// Synchronous active-high reset clears the parser and output state; max length -> 260.
`default_nettype none
module hci_h4_packet_deframer
   import hcih4_pkg::*;
(
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output      logic            req_ready,
   input  wire logic [7:0]      req_in_byte,
   output      logic            rsp_valid,
   input  wire logic            rsp_ready,
   output      logic [1:0]      rsp_out_kind,
   output      logic [7:0]      rsp_out_byte,
   output      logic            rsp_out_first,
   output      logic            rsp_out_last,
   input  wire logic            csr_wr_en,
   input  wire logic [LenW-1:0] csr_wr_data
);

   logic [LenW-1:0] max_len_ff, max_len_in;
   evt_type         evt;
   logic            evt_ready;

   assign max_len_in = csr_wr_en ? csr_wr_data : max_len_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         max_len_ff <= MaxLenReset;
      end else begin
         max_len_ff <= max_len_in;
      end
   end

   hcih4_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_in_byte (req_in_byte),
      .max_len     (max_len_ff),
      .evt_ready   (evt_ready),
      .evt         (evt)
   );

   hcih4_out u_out (
      .clock         (clock),
      .reset         (reset),
      .evt           (evt),
      .evt_ready     (evt_ready),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_first (rsp_out_first),
      .rsp_out_last  (rsp_out_last)
   );

endmodule
`default_nettype wire

// ===== sv/hcih4_checker.sv =====
// Port-level checks of the H4 deframer, bound to the top level.
`default_nettype none
`include "hci_h4_packet_deframer_macros.svh"
module hcih4_checker
   import hcih4_pkg::*;
(
   input wire logic       clock,
   input wire logic       reset,
   input wire logic       rsp_valid,
   input wire logic       rsp_ready,
   input wire logic [1:0] rsp_out_kind,
   input wire logic [7:0] rsp_out_byte,
   input wire logic       rsp_out_first,
   input wire logic       rsp_out_last
);

   `HCIH4_ASSERT_ALWAYS(a_reset_clears, clock, reset |=> !rsp_valid, "item valid after reset")

   `HCIH4_ASSERT(a_rsp_hold, clock, reset,
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_byte) && $stable(rsp_out_kind),
      "stalled item changed")

   `HCIH4_ASSERT(a_err_marks, clock, reset,
      rsp_valid && rsp_out_kind != KIND_PKT |-> rsp_out_last && !rsp_out_first,
      "error item without last mark or with first mark")

   `HCIH4_ASSERT(a_first_not_last, clock, reset,
      rsp_valid && rsp_out_first |-> !rsp_out_last && rsp_out_kind == KIND_PKT,
      "opening byte marked last or not a packet byte")

endmodule

bind hci_h4_packet_deframer hcih4_checker u_hcih4_checker (.*);
`default_nettype wire

// ===== sim/testbench.sv =====
// Self-checking testbench for the H4 packet deframer: directed and random byte streams.
`default_nettype none
module testbench;
   import hcih4_pkg::*;

   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic       first;
      logic       last;
   } deframed_type;

   logic            clock = 1'b0;
   logic            reset = 1'b1;
   logic            req_valid = 1'b0;
   logic            req_ready;
   logic [7:0]      req_in_byte = 8'h00;
   logic            rsp_valid;
   logic            rsp_ready = 1'b0;
   logic [1:0]      rsp_out_kind;
   logic [7:0]      rsp_out_byte;
   logic            rsp_out_first;
   logic            rsp_out_last;
   logic            csr_wr_en = 1'b0;
   logic [LenW-1:0] csr_wr_data = '0;

   // Shadow of the deframer state
   deframed_type    deframed_q[$];
   logic [7:0]      hdr_bytes [HdrDepth];
   int unsigned     hdr_cnt = 0;
   bit              payload_on = 1'b0;
   int unsigned     payload_left = 0;
   logic [LenW-1:0] max_len = MaxLenReset;

   bit              steady = 1'b0;   // no gaps, no stalls
   int unsigned     stall_left = 0;
   int unsigned     mismatches = 0;
   int unsigned     n_items = 0;
   int unsigned     n_rsp = 0;
   int unsigned     n_pkts = 0;
   int unsigned     n_bad_type = 0;
   int unsigned     n_oversize = 0;

   hci_h4_packet_deframer u_dut (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_in_byte   (req_in_byte),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ready),
      .rsp_out_kind  (rsp_out_kind),
      .rsp_out_byte  (rsp_out_byte),
      .rsp_out_first (rsp_out_first),
      .rsp_out_last  (rsp_out_last),
      .csr_wr_en     (csr_wr_en),
      .csr_wr_data   (csr_wr_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   initial begin
      #10000000;
      $display("hci_h4_packet_deframer test failed");
      $finish;
   end

   function automatic int unsigned h4_header_size(input logic [7:0] t);
      case (t)
         TYPE_CMD: return 4;
         TYPE_ACL: return 5;
         TYPE_SCO: return 4;
         TYPE_EVT: return 3;
         default:  return 0;
      endcase
   endfunction

   function automatic void push_out(input kind_type k, input logic [7:0] d,
                                    input logic f, input logic l);
      deframed_type r;
      r.kind  = k;
      r.data  = d;
      r.first = f;
      r.last  = l;
      deframed_q.push_back(r);
   endfunction

   // Advance the shadow state by one accepted byte, queueing what it releases.
   function automatic void deframe_byte(input logic [7:0] b);
      int unsigned hl;
      int unsigned plen;
      if (payload_on) begin
         if (payload_left > 0) payload_left--;
         push_out(KIND_PKT, b, 1'b0, payload_left == 0);
         if (payload_left == 0) payload_on = 1'b0;
         return;
      end
      if (hdr_cnt == 0) begin
         if (h4_header_size(b) == 0) push_out(KIND_BAD_TYPE, b, 1'b0, 1'b1);
         else begin
            hdr_bytes[0] = b;
            hdr_cnt = 1;
         end
         return;
      end
      hdr_bytes[hdr_cnt] = b;
      hdr_cnt++;
      hl = h4_header_size(hdr_bytes[0]);
      if (hdr_cnt < hl) return;
      if (hdr_bytes[0] == TYPE_ACL) plen = {hdr_bytes[4], hdr_bytes[3]};
      else if (hdr_bytes[0] == TYPE_EVT) plen = hdr_bytes[2];
      else plen = hdr_bytes[3];
      hdr_cnt = 0;
      if (hl + plen > max_len) begin
         push_out(KIND_OVERSIZE, hdr_bytes[0], 1'b0, 1'b1);
         return;
      end
      for (int i = 0; i < hl; i++)
         push_out(KIND_PKT, hdr_bytes[i], i == 0, (i == hl - 1) && (plen == 0));
      if (plen > 0) begin
         payload_on = 1'b1;
         payload_left = plen;
      end
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function automatic void check_field(input string name, input int unsigned exp_v,
                                       input int unsigned act_v);
      if (exp_v != act_v) begin
         mismatches++;
         $display("%0t: %s mismatch, expected %0d actual %0d", $realtime, name, exp_v, act_v);
      end
   endfunction

   // Result side: random stalls unless steady; handshakes sampled mid-cycle, where nothing moves.
   always @(posedge clock) begin
      if (steady) rsp_ready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if ($urandom_range(0, 99) < 25) begin
         stall_left <= pick_gap();
         rsp_ready <= 1'b0;
      end else rsp_ready <= 1'b1;
   end

   initial begin
      deframed_type exp_r;
      forever begin
         @(negedge clock);
         if (!reset && rsp_valid && rsp_ready) begin
            n_rsp++;
            if (deframed_q.size() == 0) begin
               mismatches++;
               $display("%0t: unexpected item, kind %0d byte %0d", $realtime, rsp_out_kind,
                        rsp_out_byte);
            end else begin
               exp_r = deframed_q.pop_front();
               check_field("kind", exp_r.kind, rsp_out_kind);
               check_field("byte", exp_r.data, rsp_out_byte);
               check_field("first", exp_r.first, rsp_out_first);
               check_field("last", exp_r.last, rsp_out_last);
               if (exp_r.kind == KIND_BAD_TYPE) n_bad_type++;
               if (exp_r.kind == KIND_OVERSIZE) n_oversize++;
               if (exp_r.first) n_pkts++;
            end
         end
      end
   end

   task automatic send_byte(input logic [7:0] b);
      int unsigned gap;
      gap = steady ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      @(negedge clock);
      while (!req_ready) @(negedge clock);
      @(posedge clock);
      deframe_byte(b);
      n_items++;
   endtask

   // Header with the given length field; the payload is sent only if it fits, else up to three stray bytes.
   task automatic send_packet(input logic [7:0] ptype, input int unsigned plen);
      logic [7:0]  hdr [HdrDepth];
      int unsigned hl;
      int unsigned n_body;
      hdr[0] = ptype;
      hdr[1] = 8'($urandom_range(0, 255));
      hdr[2] = 8'($urandom_range(0, 255));
      hl = h4_header_size(ptype);
      case (ptype)
         TYPE_ACL: begin
            hdr[3] = plen[7:0];
            hdr[4] = plen[15:8];
         end
         TYPE_EVT: begin
            plen = plen & 8'hFF;
            hdr[2] = plen[7:0];
         end
         default: begin
            plen = plen & 8'hFF;
            hdr[3] = plen[7:0];
         end
      endcase
      n_body = (hl + plen <= max_len) ? plen : $urandom_range(0, 3);
      for (int i = 0; i < hl; i++) send_byte(hdr[i]);
      for (int i = 0; i < n_body; i++) send_byte(8'($urandom_range(0, 255)));
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (deframed_q.size() != 0) @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic set_max_len(input logic [LenW-1:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      max_len = v;
      csr_wr_en <= 1'b0;
   endtask

   task automatic test_unknown_types();
      send_byte(8'h00);
      send_byte(8'hFF);
      send_byte(8'h05);
      wait_idle();
   endtask

   task automatic test_each_type();
      send_packet(TYPE_CMD, 0);   // empty payload: last on final header byte
      send_packet(TYPE_EVT, 2);
      send_packet(TYPE_SCO, 1);
      send_packet(TYPE_ACL, 3);
      wait_idle();
   endtask

   // Just over the default limit, then totals on both sides of a small limit.
   task automatic test_length_limit();
      send_packet(TYPE_ACL, 256);
      wait_idle();
      set_max_len(17'd10);
      send_packet(TYPE_EVT, 7);
      send_packet(TYPE_EVT, 8);
      send_packet(TYPE_ACL, 5);
      send_packet(TYPE_ACL, 6);
      wait_idle();
   endtask

   task automatic test_max_len_extremes();
      set_max_len(17'd3);
      send_packet(TYPE_EVT, 0);
      send_packet(TYPE_EVT, 1);
      send_packet(TYPE_CMD, 0);
      send_packet(TYPE_ACL, 0);
      wait_idle();
      set_max_len(17'd65539);
      send_packet(TYPE_ACL, 16'hFFFF);
      wait_idle();
   endtask

   // Limit changes while a header is half in; the value at header end applies.
   task automatic test_csr_mid_header();
      set_max_len(MaxLenReset);
      send_byte(TYPE_EVT);
      wait_idle();
      set_max_len(17'd4);
      send_byte(8'h0E);
      send_byte(8'h05);
      wait_idle();
      send_byte(TYPE_ACL);
      send_byte(8'h01);
      wait_idle();
      set_max_len(MaxLenReset);
      send_byte(8'h00);
      send_byte(8'h02);
      send_byte(8'h00);
      send_byte(8'hA5);
      send_byte(8'h5A);
      wait_idle();
   endtask

   task automatic test_random_stream(input int unsigned n, input bit no_idle);
      int unsigned start;
      int unsigned r;
      int unsigned plen;
      bit          paused;
      logic [7:0]  ptype;
      start = n_items;
      paused = 1'b0;
      steady = no_idle;
      while (n_items - start < n) begin
         if (!paused && n_items - start >= n / 2) begin
            wait_idle();
            paused = 1'b1;
         end
         r = $urandom_range(0, 99);
         case ($urandom_range(0, 3))
            0: ptype = TYPE_CMD;
            1: ptype = TYPE_ACL;
            2: ptype = TYPE_SCO;
            default: ptype = TYPE_EVT;
         endcase
         if (r < 12) send_byte(8'($urandom_range(0, 255)));
         else if (r < 18) begin
            // header cut short; the next packet runs into it
            send_byte(ptype);
            send_byte(8'($urandom_range(0, 255)));
         end else begin
            r = $urandom_range(0, 99);
            if (r < 65) plen = $urandom_range(0, 6);
            else if (r < 88) plen = $urandom_range(7, 20);
            else if (r < 95) plen = $urandom_range(21, 40);
            else plen = $urandom_range(256, 65535);
            // long lengths only where they give an oversize drop
            if (plen > 255 && (ptype != TYPE_ACL || plen + 5 <= max_len)) plen = plen & 8'h1F;
            send_packet(ptype, plen);
         end
      end
      wait_idle();
      steady = 1'b0;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_unknown_types();
      test_each_type();
      test_length_limit();
      test_max_len_extremes();
      test_csr_mid_header();
      test_random_stream(20, 1'b0);
      set_max_len(LenW'($urandom_range(3, 40)));
      test_random_stream(20, 1'b0);
      set_max_len(17'd65540);
      test_random_stream(20, 1'b1);
      wait_idle();
      $display("Sent %0d bytes, checked %0d items: %0d packets, %0d bad types, %0d oversize",
               n_items, n_rsp, n_pkts, n_bad_type, n_oversize);
      $display("Limits run: 3, 4, 10, 260, random small, 65539, 65540; mid-header limit change");
      if (mismatches == 0) $display("hci_h4_packet_deframer test passed");
      else $display("hci_h4_packet_deframer test failed");
      $finish;
   end

endmodule
`default_nettype wire

// ===== sim.f =====
+incdir+sv
sv/hcih4_pkg.sv
sv/hcih4_parse.sv
sv/hcih4_out.sv
sv/hci_h4_packet_deframer.sv
sv/hcih4_checker.sv
sim/testbench.sv
